@@ hdl/tpsd_pkg.sv @@
// Shared types and constants for the tape pulse signal detector.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package tpsd_pkg;

    localparam int RUN_COUNT_BITS = 24;
    localparam int SAMPLE_W       = 16;
    localparam int LEVEL_W        = 15;
    localparam int WIDTH_W        = 12;
    localparam int THRESH_W       = 20;
    localparam int PULSE_W        = 13;
    localparam int ACCUM_W        = 21;
    localparam int ADDR_W         = 4;
    localparam int DATA_W         = 32;
    localparam int S_TDATA_W      = 16;
    localparam int M_TDATA_W      = 56;

    localparam logic [PULSE_W-1:0] PULSE_MAX = '1;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_COMP_LEVEL = 2'd0;
    localparam logic [1:0] REG_MAX_WIDTH  = 2'd1;
    localparam logic [1:0] REG_THRESHOLD  = 2'd2;

    localparam logic [LEVEL_W-1:0]  RST_COMP_LEVEL = LEVEL_W'(8192);
    localparam logic [WIDTH_W-1:0]  RST_MAX_WIDTH  = WIDTH_W'(55);
    localparam logic [THRESH_W-1:0] RST_THRESHOLD  = THRESH_W'(2646);

    typedef struct packed {
        logic [LEVEL_W-1:0]  comp_level;
        logic [WIDTH_W-1:0]  max_width;
        logic [THRESH_W-1:0] threshold;
    } cfg_t;

    // Accumulator work caused by one sample: an optional pulse-end update
    // followed by an optional long-pulse subtraction.
    typedef struct packed {
        logic               end_en;
        logic               end_add;
        logic [PULSE_W-1:0] end_amt;
        logic               long_en;
        logic [PULSE_W-1:0] long_amt;
    } pulse_ev_t;

endpackage

@@ hdl/tpsd_regs.sv @@
// APB configuration registers of the tape pulse signal detector.
// Depends on tpsd_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module tpsd_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tpsd_pkg::ADDR_W-1:0]  paddr,
    input  logic [tpsd_pkg::DATA_W-1:0]  pwdata,
    output logic [tpsd_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output tpsd_pkg::cfg_t               cfg
);
    import tpsd_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] idx;
    logic       wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_COMP_LEVEL: cfg_next.comp_level = pwdata[LEVEL_W-1:0];
                REG_MAX_WIDTH:  cfg_next.max_width  = pwdata[WIDTH_W-1:0];
                REG_THRESHOLD:  cfg_next.threshold  = pwdata[THRESH_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_COMP_LEVEL: prdata = DATA_W'(cfg_reg.comp_level);
            REG_MAX_WIDTH:  prdata = DATA_W'(cfg_reg.max_width);
            REG_THRESHOLD:  prdata = DATA_W'(cfg_reg.threshold);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.comp_level <= RST_COMP_LEVEL;
            cfg_reg.max_width  <= RST_MAX_WIDTH;
            cfg_reg.threshold  <= RST_THRESHOLD;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ hdl/tpsd_pulse.sv @@
// Hysteresis comparator and pulse length tracker of the detector.
// Depends on tpsd_pkg; produces the accumulator events for each sample.
`timescale 1ns / 1ps

module tpsd_pulse (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic [tpsd_pkg::SAMPLE_W-1:0] sample,
    input  tpsd_pkg::cfg_t                cfg,
    output logic                          level_next,
    output tpsd_pkg::pulse_ev_t           ev
);
    import tpsd_pkg::*;

    logic               level_reg;
    logic [PULSE_W-1:0] len_reg;
    logic [PULSE_W-1:0] len_next;
    logic               charged_reg;
    logic               charged_next;

    logic signed [SAMPLE_W:0] s_ext;
    logic signed [SAMPLE_W:0] lvl_pos;
    logic signed [SAMPLE_W:0] lvl_neg;
    logic                     cont;
    logic [PULSE_W-1:0]       len_base;
    logic                     charged_base;
    logic                     is_long;

    assign s_ext   = $signed({sample[SAMPLE_W-1], sample});
    assign lvl_pos = $signed({2'b00, cfg.comp_level});
    assign lvl_neg = -lvl_pos;
    assign cont    = level_reg ? (s_ext > lvl_neg) : (s_ext < lvl_pos);

    always_comb begin
        len_base     = cont ? len_reg : '0;
        charged_base = cont && charged_reg;
        len_next     = (len_base != PULSE_MAX) ? len_base + PULSE_W'(1) : len_base;
        is_long      = len_next > PULSE_W'(cfg.max_width);
        charged_next = charged_base || is_long;
        level_next   = cont ? level_reg : !level_reg;

        ev.end_en   = !cont && !charged_reg;
        ev.end_add  = len_reg <= PULSE_W'(cfg.max_width);
        ev.end_amt  = len_reg;
        // A pulse already charged loses one per further sample.
        ev.long_en  = is_long;
        ev.long_amt = charged_base ? PULSE_W'(1) : len_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg   <= 1'b0;
            len_reg     <= '0;
            charged_reg <= 1'b0;
        end else if (en) begin
            level_reg   <= level_next;
            len_reg     <= len_next;
            charged_reg <= charged_next;
        end
    end

endmodule

@@ hdl/tpsd_accum.sv @@
// Detect accumulator, signal type and saturating run counters.
// Depends on tpsd_pkg; consumes the events from tpsd_pulse.
`timescale 1ns / 1ps

module tpsd_accum (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  tpsd_pkg::cfg_t                      cfg,
    input  tpsd_pkg::pulse_ev_t                 ev,
    output logic                                rec_next,
    output logic [tpsd_pkg::RUN_COUNT_BITS-1:0] rec_run_next,
    output logic [tpsd_pkg::RUN_COUNT_BITS-1:0] sil_run_next
);
    import tpsd_pkg::*;

    localparam int SUM_W = RUN_COUNT_BITS + 3;
    localparam int DIF_W = ACCUM_W + 1;

    typedef struct packed {
        logic [ACCUM_W-1:0]        accum;
        logic                      rec;
        logic [RUN_COUNT_BITS-1:0] rec_cnt;
        logic [RUN_COUNT_BITS-1:0] sil_cnt;
    } acc_st_t;

    acc_st_t st_reg;
    acc_st_t st_mid;
    acc_st_t st_next;

    function automatic logic [RUN_COUNT_BITS-1:0] sat_run(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] top;
        top = $signed({{(SUM_W-RUN_COUNT_BITS){1'b0}}, {RUN_COUNT_BITS{1'b1}}});
        if (v < 0)
            return '0;
        else if (v > top)
            return {RUN_COUNT_BITS{1'b1}};
        else
            return v[RUN_COUNT_BITS-1:0];
    endfunction

    function automatic acc_st_t acc_op(input acc_st_t st, input logic add,
                                       input logic [PULSE_W-1:0] d,
                                       input logic [THRESH_W-1:0] thr);
        acc_st_t                 r;
        logic signed [DIF_W-1:0] v;
        logic signed [DIF_W-1:0] thr_s;
        logic signed [SUM_W-1:0] d_w;
        logic signed [SUM_W-1:0] rec_w;
        logic signed [SUM_W-1:0] sil_w;
        logic signed [SUM_W-1:0] acc_w;
        logic signed [SUM_W-1:0] v_w;
        r     = st;
        thr_s = $signed({2'b00, thr});
        d_w   = $signed(SUM_W'(d));
        rec_w = $signed(SUM_W'(st.rec_cnt));
        sil_w = $signed(SUM_W'(st.sil_cnt));
        acc_w = $signed(SUM_W'(st.accum));
        if (add) begin
            v   = $signed({1'b0, st.accum}) + $signed(DIF_W'(d));
            v_w = SUM_W'(v);
            if (v >= thr_s) begin
                if (!st.rec) begin
                    // The part up to the threshold is still silence.
                    r.sil_cnt = sat_run(sil_w + SUM_W'(thr_s) - acc_w);
                    r.rec_cnt = sat_run(v_w - SUM_W'(thr_s));
                    r.rec     = 1'b1;
                end else begin
                    r.rec_cnt = sat_run(rec_w + d_w);
                end
                r.accum = ACCUM_W'(thr);
            end else begin
                if (st.rec)
                    r.rec_cnt = sat_run(rec_w + d_w);
                else
                    r.sil_cnt = sat_run(sil_w + d_w);
                r.accum = v[ACCUM_W-1:0];
            end
        end else begin
            v   = $signed({1'b0, st.accum}) - $signed(DIF_W'(d));
            v_w = SUM_W'(v);
            if (v <= 0) begin
                if (st.rec) begin
                    // The part down to zero is still record.
                    r.rec_cnt = sat_run(rec_w + acc_w);
                    r.sil_cnt = sat_run(-v_w);
                    r.rec     = 1'b0;
                end else begin
                    r.sil_cnt = sat_run(sil_w + d_w);
                end
                r.accum = '0;
            end else begin
                if (!st.rec)
                    r.sil_cnt = sat_run(sil_w + d_w);
                else
                    r.rec_cnt = sat_run(rec_w + d_w);
                r.accum = v[ACCUM_W-1:0];
            end
        end
        return r;
    endfunction

    always_comb begin
        st_mid  = ev.end_en  ? acc_op(st_reg, ev.end_add, ev.end_amt, cfg.threshold) : st_reg;
        st_next = ev.long_en ? acc_op(st_mid, 1'b0, ev.long_amt, cfg.threshold) : st_mid;
    end

    assign rec_next     = st_next.rec;
    assign rec_run_next = st_next.rec_cnt;
    assign sil_run_next = st_next.sil_cnt;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else if (en) begin
            st_reg <= st_next;
        end
    end

endmodule

@@ hdl/tape_pulse_signal_detector.sv @@
// Top level of the tape pulse signal detector: APB registers, pulse tracker,
// accumulator and the output register. Depends on tpsd_pkg and all tpsd_ modules.
//
//  Channel   Direction  Payload
//  s_        in         tdata[15:0] sample
//  m_        out        tdata level_bit, record_run, silence_run; tuser is_record
//  APB       in/out     comparator_level, max_pulse_width, detect_threshold
//
// One sample per cycle unless the output stalls: each accepted sample updates the state
// and loads the output register in the same cycle; the result shows in the next cycle.
// The only per-sample path is the comparator and two chained accumulator updates.
// A new sample is taken whenever the output register is empty or being drained.
// Synchronous reset clears all state but m_tdata and m_tuser; registers take defaults.
`timescale 1ns / 1ps

module tape_pulse_signal_detector (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tpsd_pkg::S_TDATA_W-1:0] s_tdata,  // [15:0] sample
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tpsd_pkg::M_TDATA_W-1:0] m_tdata,  // [0] level_bit, [24:1] record_run,
                                                     // [48:25] silence_run, rest zero
    output logic                           m_tuser,  // [0] is_record
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tpsd_pkg::ADDR_W-1:0]    paddr,
    input  logic [tpsd_pkg::DATA_W-1:0]    pwdata,
    output logic [tpsd_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);
    import tpsd_pkg::*;

    cfg_t                      cfg;
    pulse_ev_t                 ev;
    logic                      in_xfer;
    logic                      level_next;
    logic                      rec_next;
    logic [RUN_COUNT_BITS-1:0] rec_run_next;
    logic [RUN_COUNT_BITS-1:0] sil_run_next;

    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [M_TDATA_W-1:0] m_data_next;
    logic                 m_user_reg;
    logic                 m_user_next;

    assign s_tready = !m_valid_reg || m_tready;
    assign in_xfer  = s_tvalid && s_tready;

    tpsd_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tpsd_pulse u_pulse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (in_xfer),
        .sample     (s_tdata[SAMPLE_W-1:0]),
        .cfg        (cfg),
        .level_next (level_next),
        .ev         (ev)
    );

    tpsd_accum u_accum (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (in_xfer),
        .cfg          (cfg),
        .ev           (ev),
        .rec_next     (rec_next),
        .rec_run_next (rec_run_next),
        .sil_run_next (sil_run_next)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        if (in_xfer) begin
            m_valid_next = 1'b1;
            m_data_next  = M_TDATA_W'({sil_run_next, rec_run_next, level_next});
            m_user_next  = rec_next;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`ifndef NO_ASSERTIONS
    a_no_accept_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while the output register is stalled");

    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted sample produced no result");

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending after reset");
`endif

endmodule
